@@ rtl/tbk_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer bank package
// Request codes, sequencer states and the slot record shared by the timer
// bank modules.
// ----------------------------------------------------------------------------
package tbk_pkg;

  // Request codes carried on req_type_i.
  typedef enum logic [2:0] {
    REQ_CREATE     = 3'd0,
    REQ_DELETE     = 3'd1,
    REQ_TICK       = 3'd2,
    REQ_EXECUTE    = 3'd3,
    REQ_RESET_ALL  = 3'd4,
    REQ_DELETE_ALL = 3'd5,
    REQ_READ_TIME  = 3'd6
  } tbk_req_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_FIN
  } tbk_state_e;

  // Result status codes.
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  // Execute reports at most this many slots per request.
  localparam int unsigned          MaxResults = 16;
  localparam int unsigned          ResCntW    = $clog2(MaxResults + 1);
  localparam logic [ResCntW-1:0]   ResMax     = ResCntW'(MaxResults);

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] elapsed;
    logic [31:0] limit;
    logic [31:0] count;
  } tbk_row_t;

  localparam int unsigned RowW = $bits(tbk_row_t);

  // One result as presented on the result ports.
  typedef struct packed {
    logic       status;
    logic [3:0] slot;
    logic       fired;
    logic       last;
  } tbk_res_t;

endpackage

@@ rtl/tbk_ram.sv @@
// ----------------------------------------------------------------------------
// Timer bank RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module tbk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/tbk_slot_alu.sv @@
// ----------------------------------------------------------------------------
// Timer bank slot unit
// Shared arithmetic for one slot record: saturating elapsed update on tick,
// due test and fire count on execute, clearing on reset all.
// ----------------------------------------------------------------------------
module tbk_slot_alu (
  input  tbk_pkg::tbk_req_e req_i,
  input  tbk_pkg::tbk_row_t row_i,
  input  logic [15:0]       step_i,
  output tbk_pkg::tbk_row_t row_o,
  output logic              due_o,
  output logic              retire_o
);

  logic [32:0] elapsed_sum;
  logic [31:0] count_inc;

  // Elapsed time plus step, with carry for saturation.
  assign elapsed_sum = {1'b0, row_i.elapsed} + {17'b0, step_i};
  assign count_inc   = row_i.count + 32'd1;

  // Per-request update of the record.
  always_comb begin
    row_o    = row_i;
    due_o    = 1'b0;
    retire_o = 1'b0;
    case (req_i)
      tbk_pkg::REQ_TICK: begin
        row_o.elapsed = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
      end
      tbk_pkg::REQ_EXECUTE: begin
        due_o         = (row_i.elapsed >= row_i.period);
        row_o.elapsed = 32'd0;
        row_o.count   = count_inc;
        retire_o      = (row_i.limit != 32'd0) && (count_inc >= row_i.limit);
      end
      tbk_pkg::REQ_RESET_ALL: begin
        row_o.elapsed = 32'd0;
        row_o.count   = 32'd0;
      end
      default: begin
        row_o = row_i;
      end
    endcase
  end

endmodule

@@ rtl/multi_slot_repeat_timer_bank.sv @@
// ----------------------------------------------------------------------------
// Multi slot repeat timer bank
// A pool of SLOT_COUNT timer slots with a wrapping millisecond system time,
// driven by create, delete, tick, execute, reset-all, delete-all and
// read-time requests.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start high and busy low; busy
// stays high while the sequencer works on it. Every result is shown for one
// cycle with res_valid_o high and must be taken then; last_o marks the final
// result of a request. The tick step register is written through the
// cfg_valid_i / cfg_ready_o channel while the bank is idle and no request is
// being presented.
// Flow: delete, delete-all, read-time, unknown codes and a create with a
// zero interval answer in the cycle after the request. Create walks the
// active flags one slot per cycle until it finds a free slot or the last one.
// Tick, execute and reset-all sweep the slot memory through its single read
// and write port: an active slot takes a read step and a write-back step, a
// free slot a skipped read step, and a closing step ends the sweep; execute
// streams one result per due slot, up to MaxResults, the last at the close.
// The memory port and the shared slot unit make the sweep take one slot at a time.
// Reset frees every slot, clears the system time and sets the step to 1.
// The slot memory needs no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module multi_slot_repeat_timer_bank #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] period_ms_i,
  input  logic [31:0] repeat_limit_i,
  input  logic [7:0]  target_slot_i,
  // Configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Result channel
  output logic        res_valid_o,
  output logic        status_o,
  output logic [3:0]  slot_out_o,
  output logic        fired_o,
  output logic [31:0] time_now_o,
  output logic        last_o
);

  localparam int unsigned IdxW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(SLOT_COUNT - 1);
  localparam logic [8:0]      SlotLim = 9'(SLOT_COUNT);

  tbk_pkg::tbk_state_e state_q, state_d;
  tbk_pkg::tbk_req_e   req_in, op_q, op_d;

  logic [IdxW-1:0]               idx_q, idx_d;
  logic [tbk_pkg::ResCntW-1:0]   n_q, n_d;
  logic [3:0]                    held_q, held_d;
  logic                          held_vld_q, held_vld_d;
  logic [31:0]                   period_q, period_d;
  logic [31:0]                   limit_q, limit_d;
  logic [SLOT_COUNT-1:0]         active_q, active_d;
  logic [31:0]                   time_q, time_d;
  logic [15:0]                   step_q;
  logic                          res_vld_q, res_vld_d;
  tbk_pkg::tbk_res_t             res_q, res_d;

  logic                          req_accept;
  logic                          idx_is_last;
  logic                          target_ok;
  logic                          rd_en, wr_en;
  tbk_pkg::tbk_row_t             rd_row, wr_row, alu_row;
  logic                          alu_due, alu_retire;

  assign req_in      = tbk_pkg::tbk_req_e'(req_type_i);
  assign req_accept  = start && !busy;
  assign idx_is_last = (idx_q == IdxLast);
  assign target_ok   = ({1'b0, target_slot_i} < SlotLim) &&
                       active_q[target_slot_i[IdxW-1:0]];

  // The step may change only when no request is being taken, so that the
  // system time and the sweep of one tick use the same step.
  assign busy        = (state_q != tbk_pkg::ST_IDLE);
  assign cfg_ready_o = !busy && !start;

  // Slot memory: one record per slot.
  tbk_ram #(
    .Width (tbk_pkg::RowW),
    .Depth (SLOT_COUNT),
    .AddrW (IdxW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_row),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_row)
  );

  // Shared slot arithmetic.
  tbk_slot_alu u_alu (
    .req_i    (op_q),
    .row_i    (rd_row),
    .step_i   (step_q),
    .row_o    (alu_row),
    .due_o    (alu_due),
    .retire_o (alu_retire)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tbk_pkg::ST_IDLE: begin
        if (req_accept) begin
          case (req_in)
            tbk_pkg::REQ_CREATE: begin
              if (period_ms_i != 32'd0) begin
                state_d = tbk_pkg::ST_FIND;
              end
            end
            tbk_pkg::REQ_TICK, tbk_pkg::REQ_EXECUTE, tbk_pkg::REQ_RESET_ALL: begin
              state_d = tbk_pkg::ST_SCAN_RD;
            end
            default: begin
              state_d = tbk_pkg::ST_IDLE;
            end
          endcase
        end
      end
      tbk_pkg::ST_FIND: begin
        if (!active_q[idx_q] || idx_is_last) begin
          state_d = tbk_pkg::ST_IDLE;
        end
      end
      tbk_pkg::ST_SCAN_RD: begin
        if (op_q == tbk_pkg::REQ_EXECUTE && n_q == tbk_pkg::ResMax) begin
          state_d = tbk_pkg::ST_FIN;
        end else if (active_q[idx_q]) begin
          state_d = tbk_pkg::ST_SCAN_WR;
        end else if (idx_is_last) begin
          state_d = tbk_pkg::ST_FIN;
        end
      end
      tbk_pkg::ST_SCAN_WR: begin
        state_d = idx_is_last ? tbk_pkg::ST_FIN : tbk_pkg::ST_SCAN_RD;
      end
      tbk_pkg::ST_FIN: begin
        state_d = tbk_pkg::ST_IDLE;
      end
      default: begin
        state_d = tbk_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control, memory access and results.
  always_comb begin
    idx_d      = idx_q;
    n_d        = n_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    op_d       = op_q;
    period_d   = period_q;
    limit_d    = limit_q;
    active_d   = active_q;
    time_d     = time_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_row     = alu_row;
    case (state_q)
      tbk_pkg::ST_IDLE: begin
        if (req_accept) begin
          op_d       = req_in;
          idx_d      = '0;
          n_d        = '0;
          held_vld_d = 1'b0;
          period_d   = period_ms_i;
          limit_d    = repeat_limit_i;
          case (req_in)
            tbk_pkg::REQ_CREATE: begin
              if (period_ms_i == 32'd0) begin
                res_vld_d = 1'b1;
                res_d     = '{status: tbk_pkg::StatusFail, slot: 4'd0,
                              fired: 1'b0, last: 1'b1};
              end
            end
            tbk_pkg::REQ_DELETE: begin
              res_vld_d = 1'b1;
              if (target_ok) begin
                active_d[target_slot_i[IdxW-1:0]] = 1'b0;
                res_d = '{status: tbk_pkg::StatusOk, slot: 4'd0,
                          fired: 1'b0, last: 1'b1};
              end else begin
                res_d = '{status: tbk_pkg::StatusFail, slot: 4'd0,
                          fired: 1'b0, last: 1'b1};
              end
            end
            tbk_pkg::REQ_TICK: begin
              time_d = time_q + {16'b0, step_q};
            end
            tbk_pkg::REQ_EXECUTE, tbk_pkg::REQ_RESET_ALL: begin
              res_vld_d = 1'b0;
            end
            tbk_pkg::REQ_DELETE_ALL: begin
              active_d  = '0;
              res_vld_d = 1'b1;
              res_d     = '{status: tbk_pkg::StatusOk, slot: 4'd0,
                            fired: 1'b0, last: 1'b1};
            end
            tbk_pkg::REQ_READ_TIME: begin
              res_vld_d = 1'b1;
              res_d     = '{status: tbk_pkg::StatusOk, slot: 4'd0,
                            fired: 1'b0, last: 1'b1};
            end
            default: begin
              res_vld_d = 1'b1;
              res_d     = '{status: tbk_pkg::StatusFail, slot: 4'd0,
                            fired: 1'b0, last: 1'b1};
            end
          endcase
        end
      end
      // Create: walk the active flags for the lowest free slot.
      tbk_pkg::ST_FIND: begin
        if (!active_q[idx_q]) begin
          wr_en     = 1'b1;
          wr_row    = '{period: period_q, elapsed: 32'd0,
                        limit: limit_q, count: 32'd0};
          active_d[idx_q] = 1'b1;
          res_vld_d = 1'b1;
          res_d     = '{status: tbk_pkg::StatusOk, slot: 4'(idx_q),
                        fired: 1'b0, last: 1'b1};
        end else if (idx_is_last) begin
          res_vld_d = 1'b1;
          res_d     = '{status: tbk_pkg::StatusFail, slot: 4'd0,
                        fired: 1'b0, last: 1'b1};
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      // Sweep: read the record of an active slot, skip a free one.
      tbk_pkg::ST_SCAN_RD: begin
        if (!(op_q == tbk_pkg::REQ_EXECUTE && n_q == tbk_pkg::ResMax)) begin
          if (active_q[idx_q]) begin
            rd_en = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      // Sweep: write back the updated record (for execute, only that of a due slot).
      tbk_pkg::ST_SCAN_WR: begin
        idx_d = idx_q + 1'b1;
        if (op_q == tbk_pkg::REQ_EXECUTE) begin
          if (alu_due) begin
            wr_en = 1'b1;
            if (alu_retire) begin
              active_d[idx_q] = 1'b0;
            end
            // The previous report is now known not to be the final one.
            if (held_vld_q) begin
              res_vld_d = 1'b1;
              res_d     = '{status: tbk_pkg::StatusOk, slot: held_q,
                            fired: 1'b1, last: 1'b0};
            end
            held_d     = 4'(idx_q);
            held_vld_d = 1'b1;
            n_d        = n_q + 1'b1;
          end
        end else begin
          wr_en = 1'b1;
        end
      end
      // Closing result of a sweep.
      tbk_pkg::ST_FIN: begin
        res_vld_d = 1'b1;
        if (op_q == tbk_pkg::REQ_EXECUTE && held_vld_q) begin
          res_d = '{status: tbk_pkg::StatusOk, slot: held_q,
                    fired: 1'b1, last: 1'b1};
        end else begin
          res_d = '{status: tbk_pkg::StatusOk, slot: 4'd0,
                    fired: 1'b0, last: 1'b1};
        end
      end
      default: begin
        res_vld_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tbk_pkg::ST_IDLE;
      active_q   <= '0;
      time_q     <= 32'd0;
      step_q     <= 16'd1;
      res_vld_q  <= 1'b0;
      held_vld_q <= 1'b0;
      n_q        <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      time_q     <= time_d;
      res_vld_q  <= res_vld_d;
      held_vld_q <= held_vld_d;
      n_q        <= n_d;
      idx_q      <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    held_q   <= held_d;
    period_q <= period_d;
    limit_q  <= limit_d;
    res_q    <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign status_o    = res_q.status;
  assign slot_out_o  = res_q.slot;
  assign fired_o     = res_q.fired;
  assign last_o      = res_q.last;
  assign time_now_o  = time_q;

  // Every accepted request is either in progress or answered next cycle.
  a_req_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> (state_q != tbk_pkg::ST_IDLE) || res_vld_q)
    else $error("accepted request neither in progress nor answered");

  // The final result of a request always returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.last |-> state_q == tbk_pkg::ST_IDLE)
    else $error("final result shown while sequencer still busy");

  // The slot memory is written only by create or the write-back step.
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == tbk_pkg::ST_FIND) || (state_q == tbk_pkg::ST_SCAN_WR))
    else $error("slot memory written outside create or sweep");

  // Execute never reports more slots than the result limit.
  a_res_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= tbk_pkg::ResMax)
    else $error("execute report count over limit");

  // A successful create leaves the claimed slot active.
  a_create_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tbk_pkg::ST_FIND) && !active_q[idx_q] |=> active_q[$past(idx_q)])
    else $error("created slot not marked active");

endmodule

@@ dv/multi_slot_repeat_timer_bank_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives create, delete, tick, execute, reset-all, delete-all, read-time and
// unknown requests into the timer bank under several tick steps. A scoreboard
// keeps its own copy of the slot table and system time, predicts every result
// of each accepted request and compares the result stream field by field.
// ----------------------------------------------------------------------------
module multi_slot_repeat_timer_bank_test;

  localparam int unsigned SlotCount = 16;
  localparam logic [2:0]  ReqUnknown = 3'd7;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit = 4_000_000;

  // One result as the bank reports it.
  typedef struct packed {
    logic        status;
    logic [3:0]  slot;
    logic        fired;
    logic [31:0] time_now;
    logic        last;
  } timer_report_t;

  // Scoreboard: a private copy of the slot table that predicts the reports.
  class timer_bank_scoreboard;
    logic [31:0]   period_tab [SlotCount];
    logic [31:0]   elapsed_tab[SlotCount];
    logic [31:0]   limit_tab  [SlotCount];
    logic [31:0]   fires_tab  [SlotCount];
    bit            active_tab [SlotCount];
    logic [31:0]   sys_time;
    logic [15:0]   step;
    timer_report_t awaited_reports[$];
    int unsigned   errors;

    function new();
      foreach (active_tab[i]) active_tab[i] = 1'b0;
      sys_time = '0;
      step = 16'd1;
      errors = 0;
    endfunction

    function void expect_report(logic status, logic [3:0] slot, logic fired, logic last);
      timer_report_t r;
      r.status = status;
      r.slot = slot;
      r.fired = fired;
      r.time_now = sys_time;
      r.last = last;
      awaited_reports.push_back(r);
    endfunction

    // Apply one accepted request to the slot table and queue its reports.
    function void apply_request(logic [2:0] req, logic [31:0] period, logic [31:0] limit,
                                logic [7:0] target);
      int    free_slot;
      int    due_count;
      logic [32:0] sum;
      free_slot = -1;
      due_count = 0;
      case (req)
        tbk_pkg::REQ_CREATE: begin
          if (period != 0) begin
            for (int i = SlotCount - 1; i >= 0; i--) begin
              if (!active_tab[i]) free_slot = i;
            end
          end
          if (free_slot < 0) begin
            expect_report(tbk_pkg::StatusFail, 4'd0, 1'b0, 1'b1);
          end else begin
            period_tab[free_slot] = period;
            elapsed_tab[free_slot] = '0;
            limit_tab[free_slot] = limit;
            fires_tab[free_slot] = '0;
            active_tab[free_slot] = 1'b1;
            expect_report(tbk_pkg::StatusOk, 4'(free_slot), 1'b0, 1'b1);
          end
        end
        tbk_pkg::REQ_DELETE: begin
          if (target >= SlotCount || !active_tab[target]) begin
            expect_report(tbk_pkg::StatusFail, 4'd0, 1'b0, 1'b1);
          end else begin
            active_tab[target] = 1'b0;
            expect_report(tbk_pkg::StatusOk, 4'd0, 1'b0, 1'b1);
          end
        end
        tbk_pkg::REQ_TICK: begin
          sys_time = sys_time + 32'(step);
          // Elapsed time saturates instead of wrapping.
          for (int i = 0; i < SlotCount; i++) begin
            if (active_tab[i]) begin
              sum = {1'b0, elapsed_tab[i]} + 33'(step);
              elapsed_tab[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
          end
          expect_report(tbk_pkg::StatusOk, 4'd0, 1'b0, 1'b1);
        end
        tbk_pkg::REQ_EXECUTE: begin
          for (int i = 0; i < SlotCount && due_count < tbk_pkg::MaxResults; i++) begin
            if (active_tab[i] && elapsed_tab[i] >= period_tab[i]) begin
              fires_tab[i] = fires_tab[i] + 1;
              elapsed_tab[i] = '0;
              if (limit_tab[i] != 0 && fires_tab[i] >= limit_tab[i]) active_tab[i] = 1'b0;
              expect_report(tbk_pkg::StatusOk, 4'(i), 1'b1, 1'b0);
              due_count++;
            end
          end
          // Nothing due still gives one empty report.
          if (due_count == 0) expect_report(tbk_pkg::StatusOk, 4'd0, 1'b0, 1'b1);
          else awaited_reports[awaited_reports.size() - 1].last = 1'b1;
        end
        tbk_pkg::REQ_RESET_ALL: begin
          for (int i = 0; i < SlotCount; i++) begin
            if (active_tab[i]) begin
              elapsed_tab[i] = '0;
              fires_tab[i] = '0;
            end
          end
          expect_report(tbk_pkg::StatusOk, 4'd0, 1'b0, 1'b1);
        end
        tbk_pkg::REQ_DELETE_ALL: begin
          foreach (active_tab[i]) active_tab[i] = 1'b0;
          expect_report(tbk_pkg::StatusOk, 4'd0, 1'b0, 1'b1);
        end
        tbk_pkg::REQ_READ_TIME: begin
          expect_report(tbk_pkg::StatusOk, 4'd0, 1'b0, 1'b1);
        end
        default: begin
          expect_report(tbk_pkg::StatusFail, 4'd0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    // Compare one observed report with the oldest prediction.
    function void check_report(logic status, logic [3:0] slot, logic fired,
                               logic [31:0] time_now, logic last);
      timer_report_t exp_r;
      if (awaited_reports.size() == 0) begin
        $error("unexpected report: slot %0d fired %0d last %0d", slot, fired, last);
        errors++;
        return;
      end
      exp_r = awaited_reports.pop_front();
      if (status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, status);
        errors++;
      end
      if (slot !== exp_r.slot) begin
        $error("slot_out: expected %0d, got %0d", exp_r.slot, slot);
        errors++;
      end
      if (fired !== exp_r.fired) begin
        $error("fired: expected %0d, got %0d", exp_r.fired, fired);
        errors++;
      end
      if (time_now !== exp_r.time_now) begin
        $error("time_now: expected %0d, got %0d", exp_r.time_now, time_now);
        errors++;
      end
      if (last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  req_type_i;
  logic [31:0] period_ms_i;
  logic [31:0] repeat_limit_i;
  logic [7:0]  target_slot_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        res_valid_o;
  logic        status_o;
  logic [3:0]  slot_out_o;
  logic        fired_o;
  logic [31:0] time_now_o;
  logic        last_o;

  timer_bank_scoreboard board;
  int unsigned          cycle_count = 0;

  multi_slot_repeat_timer_bank #(
    .SLOT_COUNT(SlotCount)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .period_ms_i   (period_ms_i),
    .repeat_limit_i(repeat_limit_i),
    .target_slot_i (target_slot_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .res_valid_o   (res_valid_o),
    .status_o      (status_o),
    .slot_out_o    (slot_out_o),
    .fired_o       (fired_o),
    .time_now_o    (time_now_o),
    .last_o        (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reports are taken in the cycle they are shown.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      board.check_report(status_o, slot_out_o, fired_o, time_now_o, last_o);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one request and hold it until the bank takes it.
  task automatic send_request(logic [2:0] req, logic [31:0] period, logic [31:0] limit,
                              logic [7:0] target);
    @(negedge clk_i);
    start <= 1'b1;
    req_type_i <= req;
    period_ms_i <= period;
    repeat_limit_i <= limit;
    target_slot_i <= target;
    do @(posedge clk_i); while (busy);
    board.apply_request(req, period, limit, target);
  endtask

  task automatic hold_off(int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted report has been seen.
  task automatic drain_reports();
    @(negedge clk_i);
    start <= 1'b0;
    while (board.awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_step(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.step = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Intervals of a few ticks so that slots fire often, with some outliers.
  function automatic logic [31:0] pick_period();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 32'd0;
    if (sel == 1) return $urandom;
    if (sel == 2) return 32'hFFFF_FFFF;
    return 32'(board.step) * $urandom_range(1, 4) - $urandom_range(0, board.step - 1);
  endfunction

  function automatic logic [31:0] pick_limit();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 5) return 32'd0;
    if (sel == 5) return $urandom;
    if (sel == 6) return 32'hFFFF_FFFF;
    return $urandom_range(1, 4);
  endfunction

  // Send one create more than there are slots, then tick and execute.
  task automatic fill_bank();
    send_request(tbk_pkg::REQ_DELETE_ALL, $urandom, $urandom, 8'($urandom));
    repeat (SlotCount + 1) begin
      send_request(tbk_pkg::REQ_CREATE, pick_period(), pick_limit(), 8'($urandom));
    end
    repeat (4) send_request(tbk_pkg::REQ_TICK, $urandom, $urandom, 8'($urandom));
    send_request(tbk_pkg::REQ_EXECUTE, $urandom, $urandom, 8'($urandom));
  endtask

  task automatic random_phase(int unsigned count, int unsigned idle_pct);
    int unsigned sel;
    logic [2:0]  req;
    logic [31:0] period;
    logic [31:0] limit;
    logic [7:0]  target;
    fill_bank();
    for (int unsigned k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      period = $urandom;
      limit = $urandom;
      target = 8'($urandom);
      if (sel < 22) req = tbk_pkg::REQ_CREATE;
      else if (sel < 34) req = tbk_pkg::REQ_DELETE;
      else if (sel < 62) req = tbk_pkg::REQ_TICK;
      else if (sel < 84) req = tbk_pkg::REQ_EXECUTE;
      else if (sel < 88) req = tbk_pkg::REQ_RESET_ALL;
      else if (sel < 91) req = tbk_pkg::REQ_DELETE_ALL;
      else if (sel < 96) req = tbk_pkg::REQ_READ_TIME;
      else req = ReqUnknown;
      if (req == tbk_pkg::REQ_CREATE) begin
        period = pick_period();
        limit = pick_limit();
      end
      if (req == tbk_pkg::REQ_DELETE && $urandom_range(0, 99) < 85) begin
        target = 8'($urandom_range(0, 15));
      end
      // Now and then wait for the bank to go quiet first.
      if ($urandom_range(0, 99) < 2) drain_reports();
      send_request(req, period, limit, target);
      // The last ten of every forty requests run without gaps.
      if ((k % 40) < 30 && $urandom_range(0, 99) < idle_pct) begin
        hold_off(($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3));
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = tbk_pkg::REQ_READ_TIME;
    period_ms_i = '0;
    repeat_limit_i = '0;
    target_slot_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 16'd1;
    board = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the smallest step.
    write_step(16'd1);
    send_request(tbk_pkg::REQ_CREATE, 32'd0, 32'd3, 8'd0);
    send_request(tbk_pkg::REQ_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(tbk_pkg::REQ_CREATE, 32'd1, 32'd1, 8'd0);
    send_request(tbk_pkg::REQ_CREATE, 32'd2, 32'd0, 8'd0);
    send_request(tbk_pkg::REQ_TICK, 32'd0, 32'd0, 8'd0);
    send_request(tbk_pkg::REQ_EXECUTE, 32'd0, 32'd0, 8'd0);
    send_request(tbk_pkg::REQ_EXECUTE, 32'd0, 32'd0, 8'd0);
    send_request(tbk_pkg::REQ_TICK, 32'd0, 32'd0, 8'd0);
    send_request(tbk_pkg::REQ_EXECUTE, 32'd0, 32'd0, 8'd0);
    send_request(tbk_pkg::REQ_DELETE, 32'd0, 32'd0, 8'hFF);
    send_request(tbk_pkg::REQ_DELETE, 32'd0, 32'd0, 8'd16);
    send_request(tbk_pkg::REQ_DELETE, 32'd0, 32'd0, 8'd1);
    send_request(tbk_pkg::REQ_DELETE, 32'd0, 32'd0, 8'd2);
    send_request(tbk_pkg::REQ_RESET_ALL, 32'd0, 32'd0, 8'd0);
    send_request(tbk_pkg::REQ_READ_TIME, 32'd0, 32'd0, 8'd0);
    send_request(ReqUnknown, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(tbk_pkg::REQ_DELETE_ALL, 32'd0, 32'd0, 8'd0);
    drain_reports();

    // Random phases under different steps and sender gaps.
    write_step(16'($urandom_range(2, 1000)));
    random_phase(95, 14);
    drain_reports();
    write_step(16'hFFFF);
    random_phase(95, 55);
    drain_reports();
    write_step(16'($urandom_range(1, 65535)));
    random_phase(95, 0);
    drain_reports();

    if (board.errors == 0 && board.awaited_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ multi_slot_repeat_timer_bank.f @@
rtl/tbk_pkg.sv
rtl/tbk_ram.sv
rtl/tbk_slot_alu.sv
rtl/multi_slot_repeat_timer_bank.sv
dv/multi_slot_repeat_timer_bank_test.sv
